@@ rtl/core/dfr_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the packet deframer.
`timescale 1ns / 1ps

package dfr_pkg;

	localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
	localparam logic [31:0] LIMIT_RESET = 32'd262144;
	localparam logic [31:0] MIN_LENGTH  = 32'd5;
	localparam int          QUEUE_DEPTH = 4;

	localparam logic       KIND_DATA = 1'b0;
	localparam logic       KIND_END  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_CRC = 2'd1;
	localparam logic [1:0] ST_LEN_ERR = 2'd2;

	typedef enum logic [3:0] {
		PH_LEN  = 4'b0001,
		PH_PAD  = 4'b0010,
		PH_DATA = 4'b0100,
		PH_CRC  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		OP_PAD     = 3'd0,
		OP_TYPE    = 3'd1,
		OP_DATA    = 3'd2,
		OP_CRC     = 3'd3,
		OP_LEN_ERR = 3'd4
	} op_t;

	// one classified stream byte, front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       last;
	} byte_op_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/core/dfr_front.sv @@
// Front end: parses length and framing, classifies each stream byte.
`timescale 1ns / 1ps

module dfr_front import dfr_pkg::*; #(
	parameter int LENGTH_BITS = 19
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             stream_byte,
	input  logic [LENGTH_BITS-1:0] max_len,
	output logic                   push,
	output byte_op_t               push_item
);

	phase_t                 phase_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	logic [LENGTH_BITS-1:0] plen_q;
	logic [3:0]             pad_q;
	logic [23:0]            len_sr_q;
	logic                   halted_q;

	logic [31:0]            len32;
	logic                   len_bad;
	logic [LENGTH_BITS-1:0] cnt_nxt;
	logic                   pad_done;
	logic                   data_done;
	logic                   quad_done;

	assign len32     = {len_sr_q, stream_byte};
	assign len_bad   = (len32 < MIN_LENGTH) || (len32 > 32'(max_len));
	assign cnt_nxt   = cnt_q + LENGTH_BITS'(1);
	assign pad_done  = cnt_q >= LENGTH_BITS'(pad_q);
	assign data_done = cnt_nxt >= (plen_q - LENGTH_BITS'(MIN_LENGTH));
	assign quad_done = cnt_q == LENGTH_BITS'(3);

	always_comb begin
		push           = 1'b0;
		push_item.op   = OP_PAD;
		push_item.data = stream_byte;
		push_item.last = 1'b0;
		if (accept && !halted_q) begin
			unique case (phase_q)
				PH_LEN: begin
					push         = quad_done && len_bad;
					push_item.op = OP_LEN_ERR;
				end
				PH_PAD: begin
					push         = 1'b1;
					push_item.op = pad_done ? OP_TYPE : OP_PAD;
				end
				PH_DATA: begin
					push         = 1'b1;
					push_item.op = OP_DATA;
				end
				PH_CRC: begin
					push           = 1'b1;
					push_item.op   = OP_CRC;
					push_item.last = quad_done;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN;
			cnt_q    <= '0;
			plen_q   <= '0;
			pad_q    <= '0;
			len_sr_q <= '0;
			halted_q <= 1'b0;
		end else if (accept && !halted_q) begin
			unique case (phase_q)
				PH_LEN: begin
					len_sr_q <= len32[23:0];
					if (quad_done) begin
						cnt_q <= '0;
						if (len_bad) begin
							halted_q <= 1'b1;
						end else begin
							plen_q  <= len32[LENGTH_BITS-1:0];
							pad_q   <= 4'd8 - {1'b0, len32[2:0]};
							phase_q <= PH_PAD;
						end
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				PH_PAD: begin
					if (pad_done) begin
						cnt_q   <= '0;
						phase_q <= (plen_q <= LENGTH_BITS'(MIN_LENGTH)) ? PH_CRC : PH_DATA;
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				PH_DATA: begin
					if (data_done) begin
						cnt_q   <= '0;
						phase_q <= PH_CRC;
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				PH_CRC: begin
					if (quad_done) begin
						cnt_q   <= '0;
						phase_q <= PH_LEN;
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				default: begin
					phase_q <= PH_LEN;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/dfr_queue.sv @@
// Small FIFO of classified bytes between front and back.
`timescale 1ns / 1ps

module dfr_queue import dfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  byte_op_t push_item,
	input  logic     pop,
	output logic     full,
	output logic     not_empty,
	output byte_op_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	byte_op_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/dfr_back.sv @@
// Back end: CRC accumulation, CRC compare and the output record register.
`timescale 1ns / 1ps

module dfr_back import dfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  byte_op_t   q_head,
	output logic       q_pop,
	output logic       record_valid,
	input  logic       record_ready,
	output logic       record_kind,
	output logic [7:0] payload_byte,
	output logic [7:0] message_type,
	output logic [1:0] status,
	output logic       last_of_packet
);

	logic [31:0] crc_q;
	logic [31:0] rx_crc_q;
	logic [7:0]  type_q;
	logic        valid_q;
	logic        kind_q;
	logic [7:0]  payload_q;
	logic [7:0]  msg_type_q;
	logic [1:0]  status_q;
	logic        last_q;

	logic        needs_out;
	logic        out_free;
	logic [31:0] crc_nxt;
	logic [31:0] rx_nxt;

	assign needs_out = (q_head.op == OP_DATA) || (q_head.op == OP_LEN_ERR)
		|| ((q_head.op == OP_CRC) && q_head.last);
	assign out_free  = !valid_q || record_ready;
	assign q_pop     = q_valid && (!needs_out || out_free);
	assign crc_nxt   = crc32_byte(crc_q, q_head.data);
	assign rx_nxt    = {rx_crc_q[23:0], q_head.data};

	assign record_valid   = valid_q;
	assign record_kind    = kind_q;
	assign payload_byte   = payload_q;
	assign message_type   = msg_type_q;
	assign status         = status_q;
	assign last_of_packet = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			crc_q    <= '0;
			rx_crc_q <= '0;
			type_q   <= '0;
		end else begin
			if (valid_q && record_ready) begin
				valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (needs_out) begin
					valid_q <= 1'b1;
				end
				unique case (q_head.op)
					OP_PAD: begin
						crc_q <= crc_nxt;
					end
					OP_TYPE: begin
						crc_q  <= crc_nxt;
						type_q <= q_head.data;
					end
					OP_DATA: begin
						crc_q <= crc_nxt;
					end
					OP_CRC: begin
						if (q_head.last) begin
							rx_crc_q <= '0;
							crc_q    <= '0;
						end else begin
							rx_crc_q <= rx_nxt;
						end
					end
					OP_LEN_ERR: begin
						crc_q <= crc_q;
					end
					default: begin
						crc_q <= crc_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && needs_out) begin
			unique case (q_head.op)
				OP_DATA: begin
					kind_q     <= KIND_DATA;
					payload_q  <= q_head.data;
					msg_type_q <= type_q;
					status_q   <= ST_OK;
					last_q     <= 1'b0;
				end
				OP_LEN_ERR: begin
					kind_q     <= KIND_END;
					payload_q  <= '0;
					msg_type_q <= '0;
					status_q   <= ST_LEN_ERR;
					last_q     <= 1'b1;
				end
				default: begin
					kind_q     <= KIND_END;
					payload_q  <= '0;
					msg_type_q <= type_q;
					status_q   <= (rx_nxt == crc_q) ? ST_OK : ST_BAD_CRC;
					last_q     <= 1'b1;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/packet_deframer_crc32_check.sv @@
// Top level of the packet deframer with CRC-32 check.
//
//  channel   | handshake                   | beat contents
//  ----------+-----------------------------+---------------------------------------
//  stream in | stream_valid / stream_ready | stream_byte
//  record out| record_valid / record_ready | record_kind, payload_byte, message_type,
//            |                             | status, last_of_packet
//  config    | cfg_wr_en                   | cfg_wr_data (max_packet_length)
//
// One stream byte per cycle while the queue is not full; a record passes the queue, then the output register.
// The front parser classifies each byte into a 4-entry queue; the back end runs the
// one-byte CRC step and fills the output register.
// stream_ready drops only while the queue is full (output stalled).
// Reset is asynchronous; a length error halts the parser until the next reset.
`timescale 1ns / 1ps

module packet_deframer_crc32_check import dfr_pkg::*; #(
	parameter int LENGTH_BITS = 19
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   stream_valid,
	output logic                   stream_ready,
	input  logic [7:0]             stream_byte,
	output logic                   record_valid,
	input  logic                   record_ready,
	output logic                   record_kind,
	output logic [7:0]             payload_byte,
	output logic [7:0]             message_type,
	output logic [1:0]             status,
	output logic                   last_of_packet,
	input  logic                   cfg_wr_en,
	input  logic [LENGTH_BITS-1:0] cfg_wr_data
);

	logic [LENGTH_BITS-1:0] max_len_q;
	logic                   accept;
	logic                   push;
	byte_op_t               push_item;
	logic                   q_full;
	logic                   q_valid;
	byte_op_t               q_head;
	logic                   q_pop;

	assign stream_ready = !q_full;
	assign accept       = stream_valid && stream_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LENGTH_BITS'(LIMIT_RESET);
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	dfr_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.stream_byte(stream_byte),
		.max_len    (max_len_q),
		.push       (push),
		.push_item  (push_item)
	);

	dfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_valid),
		.head     (q_head)
	);

	dfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.record_valid  (record_valid),
		.record_ready  (record_ready),
		.record_kind   (record_kind),
		.payload_byte  (payload_byte),
		.message_type  (message_type),
		.status        (status),
		.last_of_packet(last_of_packet)
	);

endmodule

@@ rtl/core/dfr_checker.sv @@
// Port-level checks on the record channel, bound to the top level.
`timescale 1ns / 1ps

module dfr_checker import dfr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       record_valid,
	input logic       record_ready,
	input logic       record_kind,
	input logic [7:0] payload_byte,
	input logic [7:0] message_type,
	input logic [1:0] status,
	input logic       last_of_packet
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && !record_ready |=> record_valid && $stable(payload_byte)
			&& $stable(status) && $stable(record_kind))
		else $error("record beat changed while stalled");

	a_data_rec: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_kind == KIND_DATA |-> status == ST_OK && !last_of_packet)
		else $error("payload beat with end fields");

	a_end_rec: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_kind == KIND_END |-> last_of_packet && payload_byte == 8'd0
			&& status != 2'd3)
		else $error("malformed end beat");

	a_err_rec: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && status == ST_LEN_ERR |-> record_kind == KIND_END && message_type == 8'd0)
		else $error("malformed length error beat");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_ready && status == ST_LEN_ERR |=> !record_valid)
		else $error("beat after length error");

endmodule

bind packet_deframer_crc32_check dfr_checker u_dfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.record_valid  (record_valid),
	.record_ready  (record_ready),
	.record_kind   (record_kind),
	.payload_byte  (payload_byte),
	.message_type  (message_type),
	.status        (status),
	.last_of_packet(last_of_packet)
);

@@ test/deframer_checker.sv @@
// Scoreboard for the packet deframer: follows stream and record beats and checks every record.
`timescale 1ns / 1ps

module deframer_checker import dfr_pkg::*; #(
	parameter int LENGTH_BITS = 19
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   stream_valid,
	input  logic                   stream_ready,
	input  logic [7:0]             stream_byte,
	input  logic                   record_valid,
	input  logic                   record_ready,
	input  logic                   record_kind,
	input  logic [7:0]             payload_byte,
	input  logic [7:0]             message_type,
	input  logic [1:0]             status,
	input  logic                   last_of_packet,
	input  logic                   cfg_wr_en,
	input  logic [LENGTH_BITS-1:0] cfg_wr_data,
	output int                     errors,
	output int                     pending,
	output int                     records_checked
);

	localparam logic [31:0] REFLECTED_POLY = 32'hEDB88320;
	localparam logic [31:0] LEN_MASK       = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [7:0] mtype;
		logic [1:0] st;
		logic       last;
	} record_t;

	record_t                expected_records[$];
	logic [LENGTH_BITS-1:0] limit;
	phase_t                 stage;
	int unsigned            cnt;
	logic [31:0]            plen;
	logic [3:0]             npad;
	logic [31:0]            crc_acc;
	logic [31:0]            shift_in;
	logic [7:0]             cur_type;
	logic                   stopped;

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c;
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (REFLECTED_POLY & {32{r[0] ^ b[k]}});
		end
		return r;
	endfunction

	task automatic expect_record(input logic kind, input logic [7:0] data,
		input logic [7:0] mtype, input logic [1:0] st, input logic last);
		record_t r;
		r.kind  = kind;
		r.data  = data;
		r.mtype = mtype;
		r.st    = st;
		r.last  = last;
		expected_records.push_back(r);
	endtask

	task automatic take_byte(input logic [7:0] b);
		logic [31:0] len;
		if (stopped) return;
		case (stage)
			PH_LEN: begin
				shift_in = {shift_in[23:0], b};
				cnt++;
				if (cnt == 4) begin
					len = shift_in;
					cnt = 0;
					// compared as the full 32-bit value
					if (len < MIN_LENGTH || len > 32'(limit)) begin
						stopped = 1'b1;
						expect_record(KIND_END, 8'd0, 8'd0, ST_LEN_ERR, 1'b1);
					end else begin
						plen    = len & LEN_MASK;
						npad    = 4'd8 - {1'b0, len[2:0]};
						crc_acc = '0;
						stage   = PH_PAD;
					end
				end
			end
			PH_PAD: begin
				crc_acc = crc_step(crc_acc, b);
				if (cnt >= npad) begin
					cur_type = b;
					cnt      = 0;
					stage    = (plen <= MIN_LENGTH) ? PH_CRC : PH_DATA;
				end else begin
					cnt++;
				end
			end
			PH_DATA: begin
				crc_acc = crc_step(crc_acc, b);
				expect_record(KIND_DATA, b, cur_type, ST_OK, 1'b0);
				cnt = (cnt + 1) & LEN_MASK;
				if (cnt >= plen - MIN_LENGTH) begin
					cnt   = 0;
					stage = PH_CRC;
				end
			end
			default: begin
				shift_in = {shift_in[23:0], b};
				cnt++;
				if (cnt == 4) begin
					expect_record(KIND_END, 8'd0, cur_type,
						(shift_in == crc_acc) ? ST_OK : ST_BAD_CRC, 1'b1);
					cnt      = 0;
					shift_in = '0;
					crc_acc  = '0;
					stage    = PH_LEN;
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		record_t want;
		if (!arst_n) begin
			expected_records.delete();
			limit           = LENGTH_BITS'(LIMIT_RESET);
			stage           = PH_LEN;
			cnt             = 0;
			plen            = '0;
			npad            = '0;
			crc_acc         = '0;
			shift_in        = '0;
			cur_type        = '0;
			stopped         = 1'b0;
			errors          = 0;
			pending         = 0;
			records_checked = 0;
		end else begin
			if (cfg_wr_en) limit = cfg_wr_data;
			if (record_valid && record_ready) begin
				records_checked++;
				if (expected_records.size() == 0) begin
					$error("unexpected record beat: kind %0d byte %0h type %0h status %0d",
						record_kind, payload_byte, message_type, status);
					errors++;
				end else begin
					want = expected_records.pop_front();
					check_field("record_kind", want.kind, record_kind);
					check_field("payload_byte", want.data, payload_byte);
					check_field("message_type", want.mtype, message_type);
					check_field("status", want.st, status);
					check_field("last_of_packet", want.last, last_of_packet);
				end
			end
			if (stream_valid && stream_ready) take_byte(stream_byte);
			pending = expected_records.size();
		end
	end

endmodule

@@ test/tb.sv @@
// Top of the deframer regression: clock, reset, stream stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
	import dfr_pkg::*;

	localparam int LB           = 19;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 16;

	logic          clk          = 1'b0;
	logic          arst_n       = 1'b0;
	logic          stream_valid = 1'b0;
	logic          stream_ready;
	logic [7:0]    stream_byte  = '0;
	logic          record_valid;
	logic          record_ready = 1'b0;
	logic          record_kind;
	logic [7:0]    payload_byte;
	logic [7:0]    message_type;
	logic [1:0]    status;
	logic          last_of_packet;
	logic          cfg_wr_en    = 1'b0;
	logic [LB-1:0] cfg_wr_data  = '0;

	int    errors;
	int    pending;
	int    records_checked;
	int    tx_idle_pct = 38;
	int    rx_idle_pct = 71;
	int    hold_req    = 0;
	int    hold_seen   = 0;
	int    hold_left   = 0;
	int    cur_limit   = 262144;
	int    n_bytes     = 0;
	int    n_packets   = 0;
	int    n_corrupt   = 0;
	int    n_limits    = 1;
	int    n_ignored   = 0;
	string halt_kind;

	packet_deframer_crc32_check #(.LENGTH_BITS(LB)) u_top (.*);

	deframer_checker #(.LENGTH_BITS(LB)) u_check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// output side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen    <= hold_req;
			hold_left    <= HOLD_CYCLES;
			record_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			record_ready <= 1'b0;
		end else begin
			record_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			stream_valid <= 1'b0;
			@(negedge clk);
		end
		stream_valid <= 1'b1;
		stream_byte  <= b;
		do @(posedge clk); while (!stream_ready);
		n_bytes++;
		@(negedge clk);
	endtask

	// fill < 0: random pad, type and data bytes
	task automatic send_packet(input logic [31:0] len, input bit corrupt, input int fill);
		logic [31:0] crc;
		logic [7:0]  b;
		int unsigned npad;
		crc  = '0;
		npad = 8 - (len % 8);
		for (int i = 24; i >= 0; i -= 8) send_byte(len[i +: 8]);
		for (int unsigned i = 0; i < npad + len - 4; i++) begin
			b   = (fill < 0) ? 8'($urandom) : 8'(fill);
			crc = crc32_byte(crc, b);
			send_byte(b);
		end
		if (corrupt) crc ^= 32'($urandom_range(32'hFFFF_FFFF, 1));
		for (int i = 24; i >= 0; i -= 8) send_byte(crc[i +: 8]);
		n_packets++;
		if (corrupt) n_corrupt++;
	endtask

	function automatic int unsigned pick_len();
		int unsigned cap;
		cap = ($urandom_range(15) == 0) ? 120 : 40;
		if (cap > cur_limit) cap = cur_limit;
		return $urandom_range(cap, 5);
	endfunction

	task automatic run_phase(input int budget);
		int start;
		start = n_bytes;
		while (n_bytes - start < budget) send_packet(pick_len(), $urandom_range(4) == 0, -1);
	endtask

	task automatic settle();
		stream_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_limit(input int value);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= LB'(value);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		cur_limit = value;
		n_limits++;
	endtask

	initial begin
		logic [31:0] halt_len;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// shortest packet with good CRC, then one data byte with a bad CRC
		send_packet(5, 1'b0, 'h00);
		send_packet(6, 1'b1, 'hFF);

		run_phase(200);
		set_limit(5);
		run_phase(80);

		tx_idle_pct = 71;
		rx_idle_pct = 38;
		set_limit(524287);
		send_packet($urandom_range(300, 200), 1'b0, -1);
		run_phase(150);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_limit($urandom_range(255, 40));
		hold_req++;
		run_phase(200);

		// length error halts the block for the rest of the run
		set_limit(262144);
		case ($urandom_range(2))
			0: begin
				halt_kind = "length below minimum";
				halt_len  = $urandom_range(4);
			end
			1: begin
				halt_kind = "length above limit";
				halt_len  = $urandom_range(32'hFFFF_FFFF, cur_limit + 1);
			end
			default: begin
				halt_kind = "limit below minimum";
				set_limit($urandom_range(4));
				halt_len  = $urandom_range(40, 5);
			end
		endcase
		for (int i = 24; i >= 0; i -= 8) send_byte(halt_len[i +: 8]);
		repeat (16) begin
			send_byte(8'($urandom));
			n_ignored++;
		end
		stream_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d bytes in %0d packets (%0d with a bad CRC) under %0d limits,",
			n_bytes, n_packets, n_corrupt, n_limits);
		$display("a %0d-cycle hold-off; %0d records checked; ended on %s, %0d bytes ignored.",
			HOLD_CYCLES, records_checked, halt_kind, n_ignored);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/dfr_pkg.sv
rtl/core/dfr_front.sv
rtl/core/dfr_queue.sv
rtl/core/dfr_back.sv
rtl/core/packet_deframer_crc32_check.sv
rtl/core/dfr_checker.sv
test/deframer_checker.sv
test/tb.sv
